### rtl/core/stereo_feedback_delay_line_core_macros.svh
// assertion helpers used by the top-level core
`ifndef STEREO_FEEDBACK_DELAY_LINE_CORE_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_LINE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SFDL_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfdl assertion failed");

// next-cycle implication, checked outside reset
`define SFDL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfdl assertion failed");

`endif

### rtl/core/sfdl_pkg.sv
package sfdl_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_DELAY_TARGET  = 3'd0;
  localparam logic [2:0] REG_FEEDBACK_GAIN = 3'd1;
  localparam logic [2:0] REG_WET_MIX       = 3'd2;
  localparam logic [2:0] REG_RAMP_LENGTH   = 3'd3;
  localparam logic [2:0] REG_CHANNELS_USED = 3'd4;

  localparam logic [23:0] DELAY_RESET = 24'd6144000;
  localparam logic [14:0] FB_CAP      = 15'd31130;
  localparam logic [16:0] MIX_ONE     = 17'd32768;
  localparam logic [15:0] RAMP_RESET  = 16'd2400;

  // rounding offsets for the shared multiply-accumulate
  localparam logic [15:0] BIAS_INTERP = 16'd128;
  localparam logic [15:0] BIAS_Q15    = 16'd16384;

  localparam int MAC_X_W = 32;
  localparam int MAC_Y_W = 17;

  // one operation for the multiply-accumulate unit
  typedef struct packed {
    logic                       en;
    logic                       clr;
    logic [15:0]                bias;
    logic signed [MAC_X_W-1:0]  x;
    logic [MAC_Y_W-1:0]         y;
  } mac_op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_DIV  = 12'b0000_0000_0010,
    S_ADV  = 12'b0000_0000_0100,
    S_RDA  = 12'b0000_0000_1000,
    S_RDB  = 12'b0000_0001_0000,
    S_MB   = 12'b0000_0010_0000,
    S_DLY  = 12'b0000_0100_0000,
    S_FB   = 12'b0000_1000_0000,
    S_WR   = 12'b0001_0000_0000,
    S_MIX  = 12'b0010_0000_0000,
    S_SAT  = 12'b0100_0000_0000,
    S_DONE = 12'b1000_0000_0000
  } state_t;

endpackage

### rtl/core/sfdl_mac.sv
module sfdl_mac #(
  parameter int ACC_W = 41
) (
  input  logic             clk,
  input  sfdl_pkg::mac_op_t op,
  output logic signed [ACC_W-1:0] acc
);
  import sfdl_pkg::*;

  logic signed [MAC_X_W+MAC_Y_W:0] prod;
  logic signed [ACC_W-1:0] base;

  // signed sample times unsigned coefficient
  assign prod = op.x * $signed({1'b0, op.y});
  assign base = op.clr ? $signed({{(ACC_W-16){1'b0}}, op.bias}) : acc;

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= base + $signed(prod[ACC_W-1:0]);
    end
  end
endmodule

### rtl/core/sfdl_divider.sv
module sfdl_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [24:0] num,
  input  logic [15:0]        den,
  output logic signed [24:0] quo,
  output sfdl_pkg::div_status_t status
);
  import sfdl_pkg::*;

  logic [24:0] mag;
  logic [15:0] rem;
  logic [4:0]  cnt;
  logic        neg;
  logic        busy;
  logic        done;
  logic [16:0] trial;
  logic        fits;

  // one restoring step per cycle, quotient shifts into mag
  assign trial = {rem, mag[24]};
  assign fits  = trial >= {1'b0, den};
  assign quo   = neg ? -$signed(mag) : $signed(mag);
  assign status = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        rem  <= 16'd0;
        neg  <= num[24];
        mag  <= num[24] ? 25'(-num) : 25'(num);
      end else if (busy) begin
        rem <= fits ? 16'(trial - {1'b0, den}) : trial[15:0];
        mag <= {mag[23:0], fits};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd24) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/core/sfdl_line.sv
module sfdl_line #(
  parameter int ADDR_BITS = 16,
  parameter int DATA_W    = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [ADDR_BITS-1:0] rd_addr,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_W-1:0]    wr_data,
  output logic [DATA_W-1:0]    q,
  output logic                 busy
);
  logic [DATA_W-1:0]    mem [2**ADDR_BITS];
  logic [ADDR_BITS-1:0] cnt;

  // clearing pass after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (&cnt) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[cnt] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q <= mem[rd_addr];
  end
endmodule

### rtl/core/stereo_feedback_delay_line_core.sv
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   left_in, right_in
// out      output     out_valid/out_stall left_out, right_out
// cfg      input      cfg_write           cfg_index, cfg_data
//
// each pair runs a sequence set by the shared multiply-accumulate and the single read
// port of each line, once more for the right channel in stereo; a target change adds a
// serial division. after reset a clearing pass over every line entry runs before the
// first transaction is taken. the output register holds a result while out_stall is
// high; the next item is still accepted and waits only at its own hand-off.
// LINE_DEPTH must be a power of two.
module stereo_feedback_delay_line_core #(
  parameter int LINE_DEPTH  = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  input  logic                          cfg_write,
  input  logic [2:0]                    cfg_index,
  input  logic [23:0]                   cfg_data
);
  import sfdl_pkg::*;
  `include "stereo_feedback_delay_line_core_macros.svh"

  localparam int ADDR_BITS = $clog2(LINE_DEPTH);
  localparam int PW        = ADDR_BITS + 8;
  localparam int ACC_W     = SAMPLE_BITS + 17;
  localparam int S         = SAMPLE_BITS;

  // configuration registers
  logic [23:0] delay_target;
  logic [14:0] feedback_gain;
  logic [15:0] wet_mix;
  logic [15:0] ramp_length;
  logic [1:0]  channels_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_target  <= DELAY_RESET;
      feedback_gain <= '0;
      wet_mix       <= 16'(MIX_ONE);
      ramp_length   <= RAMP_RESET;
      channels_used <= 2'd2;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DELAY_TARGET:  delay_target  <= cfg_data;
        REG_FEEDBACK_GAIN: feedback_gain <= cfg_data[14:0];
        REG_WET_MIX:       wet_mix       <= cfg_data[15:0];
        REG_RAMP_LENGTH:   ramp_length   <= cfg_data[15:0];
        REG_CHANNELS_USED: channels_used <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [14:0] fb;
  logic [16:0] wet;
  logic        stereo;
  assign fb     = (feedback_gain > FB_CAP) ? FB_CAP : feedback_gain;
  assign wet    = ({1'b0, wet_mix} > MIX_ONE) ? MIX_ONE : {1'b0, wet_mix};
  assign stereo = channels_used[1];

  function automatic logic signed [S-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed({{(ACC_W-S+1){1'b0}}, {(S-1){1'b1}}});
    lo = -hi - 1;
    if (v > hi) return hi[S-1:0];
    if (v < lo) return lo[S-1:0];
    return v[S-1:0];
  endfunction

  // state
  state_t state;
  logic [ADDR_BITS-1:0]  wi;
  logic [23:0]           cur;
  logic [23:0]           latched;
  logic signed [24:0]    step;
  logic [15:0]           rem;
  logic                  ch;
  logic signed [S-1:0]   dry_l, dry_r, res_l;
  logic signed [S-1:0]   delayed;

  // shared units
  mac_op_t                 mop;
  logic signed [ACC_W-1:0] acc;
  logic                    div_start;
  logic signed [24:0]      div_quo;
  div_status_t             div_st;
  logic signed [24:0]      div_num;

  sfdl_mac #(.ACC_W(ACC_W)) u_mac (.clk(clk), .op(mop), .acc(acc));

  assign div_num = $signed({1'b0, delay_target}) - $signed({1'b0, cur});
  sfdl_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(ramp_length),
    .quo(div_quo), .status(div_st)
  );

  // read position and taps
  logic [28:0]          ptmp;
  logic [PW-1:0]        p;
  logic [ADDR_BITS-1:0] i0, i1, rd_addr;
  logic [7:0]           f;
  assign ptmp = 29'({wi, 8'd0}) - 29'(cur);
  assign p    = ptmp[PW-1:0];
  assign i0   = p[PW-1:8];
  assign i1   = i0 + 1'b1;
  assign f    = p[7:0];
  assign rd_addr = (state == S_RDA) ? i0 : i1;

  // delay lines
  logic [S-1:0] q_l, q_r;
  logic         busy_l, busy_r;
  logic         wr_l, wr_r;
  logic signed [ACC_W-1:0] wsum;
  logic signed [S-1:0]     wdata, dry, q;
  assign dry   = ch ? dry_r : dry_l;
  assign q     = ch ? $signed(q_r) : $signed(q_l);
  assign wsum  = ACC_W'(dry) + (acc >>> 15);
  assign wdata = sat(wsum);
  assign wr_l  = (state == S_WR) && !ch;
  assign wr_r  = (state == S_WR) && ch;

  sfdl_line #(.ADDR_BITS(ADDR_BITS), .DATA_W(S)) u_left (
    .clk(clk), .rst(rst), .rd_addr(rd_addr), .wr_en(wr_l), .wr_addr(wi),
    .wr_data(wdata), .q(q_l), .busy(busy_l)
  );
  sfdl_line #(.ADDR_BITS(ADDR_BITS), .DATA_W(S)) u_right (
    .clk(clk), .rst(rst), .rd_addr(rd_addr), .wr_en(wr_r), .wr_addr(wi),
    .wr_data(wdata), .q(q_r), .busy(busy_r)
  );

  logic in_acc, out_free;
  assign in_stall = (state != S_IDLE) || busy_l || busy_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign div_start = in_acc && (delay_target != latched) && (ramp_length != 16'd0);

  // multiply-accumulate schedule
  always_comb begin
    mop = '0;
    unique case (state)
      S_RDB: mop = '{en: 1'b1, clr: 1'b1, bias: BIAS_INTERP, x: MAC_X_W'(q),
                     y: 17'(9'd256 - {1'b0, f})};
      S_MB:  mop = '{en: 1'b1, clr: 1'b0, bias: '0, x: MAC_X_W'(q), y: 17'(f)};
      S_FB:  mop = '{en: 1'b1, clr: 1'b1, bias: BIAS_Q15, x: MAC_X_W'(delayed), y: 17'(fb)};
      S_WR:  mop = '{en: 1'b1, clr: 1'b1, bias: BIAS_Q15, x: MAC_X_W'(dry),
                     y: MIX_ONE - wet};
      S_MIX: mop = '{en: 1'b1, clr: 1'b0, bias: '0, x: MAC_X_W'(delayed), y: wet};
      default: mop = '0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      wi        <= '0;
      cur       <= DELAY_RESET;
      latched   <= DELAY_RESET;
      step      <= '0;
      rem       <= '0;
      ch        <= 1'b0;
    end else begin
      // the hand-off state reloads the output itself
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            dry_l <= left_in;
            dry_r <= right_in;
            ch    <= 1'b0;
            state <= S_ADV;
            if (delay_target != latched) begin
              latched <= delay_target;
              if (ramp_length == 16'd0) begin
                cur  <= delay_target;
                rem  <= '0;
                step <= '0;
              end else begin
                rem   <= ramp_length;
                state <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            step  <= div_quo;
            state <= S_ADV;
          end
        end
        S_ADV: begin
          if (rem == 16'd0) begin
            cur <= latched;
          end else begin
            rem <= rem - 16'd1;
            cur <= (rem == 16'd1) ? latched : 24'($signed({1'b0, cur}) + step);
          end
          state <= S_RDA;
        end
        S_RDA: state <= S_RDB;
        S_RDB: state <= S_MB;
        S_MB:  state <= S_DLY;
        S_DLY: begin
          delayed <= S'(acc >>> 8);
          state   <= S_FB;
        end
        S_FB:  state <= S_WR;
        S_WR:  state <= S_MIX;
        S_MIX: state <= S_SAT;
        S_SAT: begin
          if (!ch) begin
            res_l <= sat(acc >>> 15);
          end else begin
            dry_r <= sat(acc >>> 15);
          end
          if (!ch && stereo) begin
            ch    <= 1'b1;
            state <= S_RDA;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            left_out  <= ch ? res_l : sat(acc >>> 15);
            right_out <= dry_r;
            out_valid <= 1'b1;
            wi        <= wi + 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SFDL_ASSERT_IMPL(a_div_done_in_div, clk, rst, div_st.done, state == S_DIV)
  `SFDL_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_acc, state != S_IDLE)
  `SFDL_ASSERT_IMPL(a_no_write_while_clear, clk, rst, busy_l || busy_r, state == S_IDLE)
endmodule
